[src/fdsd_pkg.sv]
// ----------------------------------------------------------------------------
// fdsd_pkg
// Shared types, constants and binary32 arithmetic helpers for the
// dot product / squared distance block.
// ----------------------------------------------------------------------------
package fdsd_pkg;

   localparam int unsigned FpWidth   = 32;
   localparam int unsigned QueueDepth = 4;

   localparam logic [31:0] PosZero   = 32'h0000_0000;
   localparam logic [31:0] CanonQnan = 32'h7FC0_0000;

   typedef enum logic [0:0] {
      MODE_DOT  = 1'b0,
      MODE_DIST = 1'b1
   } mode_type;

   // Work item handed from the front end to the back end.
   typedef struct packed {
      logic [31:0] term;
      logic        last;
   } work_type;

   // Product stage payload: unrounded fields of a product.
   typedef struct packed {
      logic        is_nan;
      logic        is_inf;
      logic        is_zero;
      logic        sign;
      logic signed [10:0] exp;
      logic [47:0] mant;
      logic        last;
   } prod_type;

   // Round-to-nearest-even packer. mant holds the significand with its
   // leading one at bit 26 (for a normal result) and 3 guard bits below the
   // 24 kept bits; exp is the biased exponent of that leading position.
   function automatic logic [31:0] fp_pack(input logic sign,
                                           input logic signed [11:0] exp_in,
                                           input logic [26:0] mant_in);
      logic [26:0] m;
      logic signed [11:0] e;
      logic [5:0]  sh;
      logic        sticky;
      logic [24:0] rnd;
      logic [31:0] r;
      m = mant_in;
      e = exp_in;
      if (m == 27'd0) begin
         r = {sign, 31'd0};
      end else begin
         if (e < 12'sd1) begin
            // subnormal: shift right, keep sticky
            if ((12'sd1 - e) > 12'sd27) sh = 6'd27;
            else sh = 6'((12'sd1 - e));
            sticky = |(m & ((27'd1 << sh) - 27'd1));
            m = (m >> sh) | {26'd0, sticky};
            e = 12'sd0;
         end
         rnd = {1'b0, m[26:3]};
         if (m[2] && (m[1] || m[0] || m[3])) rnd = rnd + 25'd1;
         if (rnd[24]) begin
            rnd = rnd >> 1;
            e = e + 12'sd1;
         end else if (e == 12'sd0 && rnd[23]) begin
            e = 12'sd1;
         end
         if (e >= 12'sd255) r = {sign, 8'hFF, 23'd0};
         else r = {sign, e[7:0], rnd[22:0]};
      end
      return r;
   endfunction

   // Unpack to significand with hidden bit and effective exponent.
   function automatic logic [24:0] fp_sig(input logic [31:0] x);
      return {1'b0, (x[30:23] != 8'd0), x[22:0]};
   endfunction

   function automatic logic [7:0] fp_exp(input logic [31:0] x);
      return (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
   endfunction

   function automatic logic fp_isnan(input logic [31:0] x);
      return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
   endfunction

   function automatic logic fp_isinf(input logic [31:0] x);
      return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
   endfunction

   // binary32 add, round to nearest even.
   function automatic logic [31:0] fp_add(input logic [31:0] x, input logic [31:0] y);
      logic [31:0] big;
      logic [31:0] lit;
      logic [7:0]  eb;
      logic [7:0]  el;
      logic [7:0]  d;
      logic [50:0] mb;
      logic [50:0] ml;
      logic [50:0] s;
      logic [5:0]  lz;
      logic signed [11:0] e;
      logic [26:0] m27;
      logic        sgn;
      logic [31:0] r;
      lz = 6'd0;
      if (fp_isnan(x) || fp_isnan(y)) begin
         r = CanonQnan;
      end else if (fp_isinf(x) && fp_isinf(y)) begin
         r = (x[31] == y[31]) ? x : CanonQnan;
      end else if (fp_isinf(x)) begin
         r = x;
      end else if (fp_isinf(y)) begin
         r = y;
      end else begin
         if (x[30:0] >= y[30:0]) begin
            big = x;
            lit = y;
         end else begin
            big = y;
            lit = x;
         end
         eb = fp_exp(big);
         el = fp_exp(lit);
         d  = eb - el;
         mb = {1'b0, fp_sig(big), 25'd0};
         ml = {1'b0, fp_sig(lit), 25'd0};
         if (d > 8'd50) ml = {50'd0, |ml};
         else ml = (ml >> d) | {50'd0, |(ml & ((51'd1 << d) - 51'd1))};
         if (big[31] == lit[31]) s = mb + ml;
         else s = mb - ml;
         sgn = big[31];
         if (s == 51'd0) begin
            r = {x[31] & y[31], 31'd0};
         end else begin
            for (int i = 0; i < 51; i++) begin
               if (s[i]) lz = 6'(50 - i);
            end
            // leading one of mb sits at bit 48 -> exponent eb
            e = $signed({4'd0, eb}) + 12'sd2 - $signed({6'd0, lz});
            s = s << lz;
            m27 = {s[50:25], |s[24:0]};
            r = fp_pack(sgn, e, m27);
         end
      end
      return r;
   endfunction

endpackage

[src/fdsd_front.sv]
// ----------------------------------------------------------------------------
// fdsd_front
// Front end: takes element pairs, forms the term (a*b or (a-b)^2) in a
// three stage pipe and pushes it into the work queue.
// ----------------------------------------------------------------------------
module fdsd_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    mode,
   input  logic                    in_valid,
   input  logic [31:0]             in_a,
   input  logic [31:0]             in_b,
   input  logic                    in_last,
   output logic                    in_ready,
   output logic                    out_valid,
   output fdsd_pkg::work_type      out_work,
   input  logic                    out_ready
);
   import fdsd_pkg::*;

   // stage 1: difference or pass-through
   logic        s1_v_ff, s1_v_in;
   logic [31:0] s1_x_ff, s1_x_in, s1_y_ff, s1_y_in;
   logic        s1_l_ff, s1_l_in;
   // stage 2: raw product
   logic        s2_v_ff, s2_v_in;
   prod_type    s2_p_ff, s2_p_in;
   // stage 3: rounded term
   logic        s3_v_ff, s3_v_in;
   work_type    s3_w_ff, s3_w_in;
   logic        adv;
   logic [31:0] diff;
   logic [23:0] sx, sy;
   logic [5:0]  lz;
   logic signed [11:0] e;
   logic [47:0] m;

   assign adv      = !s3_v_ff || out_ready;
   assign in_ready = adv;

   always_comb begin
      diff = fp_add(in_a, {~in_b[31], in_b[30:0]});
      if (mode == MODE_DIST) begin
         s1_x_in = diff;
         s1_y_in = diff;
      end else begin
         s1_x_in = in_a;
         s1_y_in = in_b;
      end
      s1_l_in = in_last;
      s1_v_in = in_valid;
   end

   always_comb begin
      sx = 24'(fp_sig(s1_x_ff));
      sy = 24'(fp_sig(s1_y_ff));
      s2_p_in.sign    = s1_x_ff[31] ^ s1_y_ff[31];
      s2_p_in.is_nan  = fp_isnan(s1_x_ff) || fp_isnan(s1_y_ff) ||
                        (fp_isinf(s1_x_ff) && s1_y_ff[30:0] == 31'd0) ||
                        (fp_isinf(s1_y_ff) && s1_x_ff[30:0] == 31'd0);
      s2_p_in.is_inf  = fp_isinf(s1_x_ff) || fp_isinf(s1_y_ff);
      s2_p_in.is_zero = (s1_x_ff[30:0] == 31'd0) || (s1_y_ff[30:0] == 31'd0);
      s2_p_in.exp     = $signed({3'd0, fp_exp(s1_x_ff)}) +
                        $signed({3'd0, fp_exp(s1_y_ff)}) - 11'sd127;
      s2_p_in.mant    = sx * sy;
      s2_p_in.last    = s1_l_ff;
      s2_v_in         = s1_v_ff;
   end

   always_comb begin
      lz = 6'd0;
      for (int i = 0; i < 48; i++) begin
         if (s2_p_ff.mant[i]) lz = 6'(47 - i);
      end
      m = s2_p_ff.mant << lz;
      // mant leading one at bit 46 means exponent exp
      e = 12'(s2_p_ff.exp) + 12'sd1 - $signed({6'd0, lz});
      if (s2_p_ff.is_nan)
         s3_w_in.term = CanonQnan;
      else if (s2_p_ff.is_inf)
         s3_w_in.term = {s2_p_ff.sign, 8'hFF, 23'd0};
      else if (s2_p_ff.is_zero)
         s3_w_in.term = {s2_p_ff.sign, 31'd0};
      else
         s3_w_in.term = fp_pack(s2_p_ff.sign, e, {m[47:22], |m[21:0]});
      s3_w_in.last = s2_p_ff.last;
      s3_v_in      = s2_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
         s3_v_ff <= s3_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_x_ff <= s1_x_in;
         s1_y_ff <= s1_y_in;
         s1_l_ff <= s1_l_in;
         s2_p_ff <= s2_p_in;
         s3_w_ff <= s3_w_in;
      end
   end

   assign out_valid = s3_v_ff;
   assign out_work  = s3_w_ff;

endmodule

[src/fdsd_queue.sv]
// ----------------------------------------------------------------------------
// fdsd_queue
// Small FIFO between front end and back end.
// ----------------------------------------------------------------------------
module fdsd_queue #(
   parameter int unsigned Depth = fdsd_pkg::QueueDepth
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  fdsd_pkg::work_type  push_data,
   output logic                not_full,
   input  logic                pop,
   output fdsd_pkg::work_type  pop_data,
   output logic                not_empty
);
   import fdsd_pkg::*;

   localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

   work_type      mem_ff [Depth];
   logic [Aw-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [Aw:0]   cnt_ff, cnt_in;

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wp_in = (wp_ff == Aw'(Depth - 1)) ? '0 : wp_ff + 1'b1;
      end
      if (pop) begin
         rp_in = (rp_ff == Aw'(Depth - 1)) ? '0 : rp_ff + 1'b1;
      end
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      else if (!push && pop) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_data;
   end

   assign pop_data  = mem_ff[rp_ff];
   assign not_empty = (cnt_ff != '0);
   assign not_full  = (cnt_ff != (Aw+1)'(Depth));

endmodule

[src/fdsd_back.sv]
// ----------------------------------------------------------------------------
// fdsd_back
// Back end: adds terms into the running sum, emits it on the last beat.
// ----------------------------------------------------------------------------
module fdsd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  fdsd_pkg::work_type  in_work,
   output logic                in_ready,
   output logic                rsp_valid,
   output logic [31:0]         rsp_metric_value,
   input  logic                rsp_stall
);
   import fdsd_pkg::*;

   logic [31:0] sum_ff, sum_in, res_ff, res_in, total;
   logic        rv_ff, rv_in;
   logic        take;

   // a non-last beat never waits; a last beat waits for the output slot
   assign in_ready = !in_work.last || !rv_ff || !rsp_stall;
   assign take     = in_valid && in_ready;
   assign total    = fp_add(sum_ff, in_work.term);

   always_comb begin
      sum_in = sum_ff;
      res_in = res_ff;
      rv_in  = rv_ff && rsp_stall;
      if (take) begin
         if (in_work.last) begin
            sum_in = PosZero;
            res_in = total;
            rv_in  = 1'b1;
         end else begin
            sum_in = total;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= PosZero;
         rv_ff  <= 1'b0;
      end else begin
         sum_ff <= sum_in;
         rv_ff  <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign rsp_valid        = rv_ff;
   assign rsp_metric_value = fp_isnan(res_ff) ? CanonQnan : res_ff;

endmodule

[src/float_dot_or_squared_distance.sv]
// ----------------------------------------------------------------------------
// float_dot_or_squared_distance
// Streaming binary32 dot product / squared distance accumulator.
// ----------------------------------------------------------------------------
// Throughput: one element pair per cycle unless req_stall is high; the
// combinational accumulator add is the loop that sets it. A last beat passes
// through the three term stages, the queue and the accumulator's result
// register before rsp_valid rises. Reset is synchronous and clears the pipe,
// the queue, the sum to +0.0 and metric_mode to dot product.
module float_dot_or_squared_distance #(
   parameter int unsigned QueueDepth = fdsd_pkg::QueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_metric_mode_we,
   input  logic        csr_metric_mode,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_a_element,
   input  logic [31:0] req_b_element,
   input  logic        req_last_element,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_metric_value
);
   import fdsd_pkg::*;

   logic     mode_ff;
   logic     f_ready, f_valid, q_full_n, q_empty_n, b_ready;
   work_type f_work, q_work;

   always_ff @(posedge clock) begin
      if (reset) mode_ff <= MODE_DOT;
      else if (csr_metric_mode_we) mode_ff <= csr_metric_mode;
   end

   assign req_stall = !f_ready;

   fdsd_front u_front (
      .clock(clock), .reset(reset), .mode(mode_ff),
      .in_valid(req_valid && f_ready), .in_a(req_a_element), .in_b(req_b_element),
      .in_last(req_last_element), .in_ready(f_ready),
      .out_valid(f_valid), .out_work(f_work), .out_ready(q_full_n)
   );

   fdsd_queue #(.Depth(QueueDepth)) u_queue (
      .clock(clock), .reset(reset),
      .push(f_valid && q_full_n), .push_data(f_work), .not_full(q_full_n),
      .pop(q_empty_n && b_ready), .pop_data(q_work), .not_empty(q_empty_n)
   );

   fdsd_back u_back (
      .clock(clock), .reset(reset),
      .in_valid(q_empty_n), .in_work(q_work), .in_ready(b_ready),
      .rsp_valid(rsp_valid), .rsp_metric_value(rsp_metric_value),
      .rsp_stall(rsp_stall)
   );

endmodule
